[hdl/chacha_pkg.sv]
// Shared types and constants for the ChaCha20 stream XOR unit.
// Holds the sequencer state type, the round count and the quarter-round index map.
// No dependencies.
package chacha_pkg;

  // Number of rounds per keystream block (8 to 20)
  localparam int unsigned ROUND_COUNT = 20;
  localparam int unsigned RoundW      = $clog2(ROUND_COUNT);

  // Configuration register indexes
  localparam logic [2:0] CFG_WORDS_12_13 = 3'd6;
  localparam int unsigned CfgCount       = 8;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } seq_state_e;

  // Map quarter-round lane and role (0=a, 1=b, 2=c, 3=d) to a block word index.
  // Column rounds use lane + 4*role; diagonal rounds shift each role by its number.
  function automatic logic [3:0] qr_index(input logic diag, input logic [1:0] lane,
                                          input logic [1:0] role);
    logic [1:0] off;
    off = lane + (diag ? role : 2'd0);
    return {role, off};
  endfunction

  // Rotate left by 16, 12, 8 or 7 for sub-steps 0 to 3
  function automatic word_t rotl_step(input word_t v, input logic [1:0] step);
    word_t r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

[hdl/chacha20_stream_xor_unit.sv]
// ChaCha20 stream XOR unit: XORs message words with a keystream generated on chip.
// Depends on chacha_pkg for the sequencer state, round count and index helpers.
// A block-start word runs its rounds in ST_ROUND and the final add in ST_FINAL before
// ST_EMIT registers its result; every other word goes from accept straight to ST_EMIT.
// A new word is accepted only in ST_IDLE, so the unit takes no word until the previous
// one is emitted, and a stalled output holds it in ST_EMIT.
// Reset clears the configuration, word position, counter and message state.
module chacha20_stream_xor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // message words in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic        end_of_message_i,
  // cipher words out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] cipher_word_o,
  output logic        last_o
);
  import chacha_pkg::*;

  seq_state_e        state_q, state_d;
  logic [63:0]       cfg_q [CfgCount];
  word_t             x_q [16];
  word_t             x_d [16];
  word_t             in_blk [16];
  logic [1:0]        step_q;
  logic [RoundW-1:0] round_q;
  logic [3:0]        pos_q;
  word_t             ctr_q;
  word_t             ctr_cur;
  logic              started_q;
  word_t             data_q;
  logic              eom_q;
  logic              out_valid_q;
  word_t             cipher_q;
  logic              last_q;

  logic in_fire, out_free, emit_fire, last_step;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_step   = (step_q == 2'd3) && (round_q == RoundW'(ROUND_COUNT - 1));
  assign ctr_cur     = started_q ? ctr_q : cfg_q[CFG_WORDS_12_13][31:0];

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (pos_q == 4'd0) ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        if (last_step) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    emit_fire  = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EMIT: emit_fire  = out_free;
      default: ;
    endcase
  end

  // Build the input block from configuration and the running counter
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_blk[2*i]   = cfg_q[i][31:0];
      in_blk[2*i+1] = cfg_q[i][63:32];
    end
    in_blk[12] = ctr_cur;
  end

  // Shared round unit: load the input block, one sub-step of four quarter-rounds, or the final add
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    logic [3:0] ip, iq, ir;
    word_t      sum;
    ia  = 4'd0;
    ib  = 4'd0;
    ic  = 4'd0;
    id  = 4'd0;
    ip  = 4'd0;
    iq  = 4'd0;
    ir  = 4'd0;
    sum = '0;
    for (int i = 0; i < 16; i++) begin
      x_d[i] = x_q[i];
    end
    case (state_q)
      ST_IDLE: begin
        for (int i = 0; i < 16; i++) begin
          x_d[i] = in_blk[i];
        end
      end
      ST_ROUND: begin
        for (int k = 0; k < 4; k++) begin
          ia = qr_index(round_q[0], 2'(k), 2'd0);
          ib = qr_index(round_q[0], 2'(k), 2'd1);
          ic = qr_index(round_q[0], 2'(k), 2'd2);
          id = qr_index(round_q[0], 2'(k), 2'd3);
          // even sub-steps update a and d, odd ones c and b
          ip = step_q[0] ? ic : ia;
          iq = step_q[0] ? id : ib;
          ir = step_q[0] ? ib : id;
          sum = x_q[ip] + x_q[iq];
          x_d[ip] = sum;
          x_d[ir] = rotl_step(x_q[ir] ^ sum, step_q);
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 16; i++) begin
          x_d[i] = x_q[i] + in_blk[i];
        end
      end
      default: ;
    endcase
  end

  // Hold the block state; load on a block start, advance in rounds and final add
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE && in_fire && pos_q == 4'd0) ||
        state_q == ST_ROUND || state_q == ST_FINAL) begin
      for (int i = 0; i < 16; i++) begin
        x_q[i] <= x_d[i];
      end
    end
    if (in_fire) begin
      data_q <= data_word_i;
      eom_q  <= end_of_message_i;
    end
    if (emit_fire) begin
      cipher_q <= data_q ^ x_q[pos_q];
      last_q   <= eom_q;
    end
  end

  // Control state: sequencer, counters, message tracking, output valid, config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 2'd0;
      round_q     <= '0;
      pos_q       <= 4'd0;
      ctr_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CfgCount; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < 4'(CfgCount)) begin
        cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
      end
      if (in_fire) begin
        ctr_q     <= ctr_cur;
        started_q <= 1'b1;
        step_q    <= 2'd0;
        round_q   <= '0;
      end
      if (state_q == ST_ROUND) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          round_q <= round_q + RoundW'(1);
        end
      end
      // advance position; restart after the final word
      if (emit_fire) begin
        if (eom_q) begin
          pos_q     <= 4'd0;
          started_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 4'd1;
          if (pos_q == 4'd15) begin
            ctr_q <= ctr_q + 32'd1;
          end
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_word_o = cipher_q;
  assign last_o        = last_q;

endmodule

[test/tb_top.sv]
// Self-checking bench for chacha20_stream_xor_unit: random message words with
// register reloads between phases, checked against an in-bench keystream predictor.
// Depends on chacha_pkg (word type, round count, register indexes) and the unit.
module tb_top;
  import chacha_pkg::*;

  typedef struct packed {
    word_t data;
    logic  eom;
  } plain_word_t;

  typedef struct packed {
    word_t cipher;
    logic  last;
  } cipher_word_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i      = '0;
  logic [63:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [31:0] data_word_i      = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [31:0] cipher_word_o;
  logic        last_o;

  chacha20_stream_xor_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_word_i     (data_word_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_word_o   (cipher_word_o),
    .last_o          (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: shadow registers, keystream block, position and counter
  logic [63:0] cfg_shadow [CfgCount];
  word_t       mix        [16];
  word_t       key_words  [16];
  logic [3:0]  word_pos   = '0;
  word_t       blk_ctr    = '0;
  logic        msg_open   = 1'b0;

  plain_word_t  plain_word_q [$];
  cipher_word_t expected_cipher_q [$];

  int err_count   = 0;
  int words_sent  = 0;
  int words_seen  = 0;
  int msg_count   = 0;
  int cfg_writes  = 0;

  initial begin
    for (int i = 0; i < CfgCount; i++) cfg_shadow[i] = '0;
  end

  function automatic word_t rotate_left(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void mix_quarter(int a, int b, int c, int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rotate_left(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rotate_left(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rotate_left(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rotate_left(mix[b] ^ mix[c], 7);
  endfunction

  // Build the sixteen keystream words from the shadow registers and counter
  function automatic void build_keystream();
    word_t init_w [16];
    for (int i = 0; i < CfgCount; i++) begin
      init_w[2*i]   = cfg_shadow[i][31:0];
      init_w[2*i+1] = cfg_shadow[i][63:32];
    end
    init_w[12] = blk_ctr;
    for (int i = 0; i < 16; i++) mix[i] = init_w[i];
    for (int r = 0; r < ROUND_COUNT; r++) begin
      if (r % 2 == 0) begin
        mix_quarter(0, 4, 8, 12);
        mix_quarter(1, 5, 9, 13);
        mix_quarter(2, 6, 10, 14);
        mix_quarter(3, 7, 11, 15);
      end else begin
        mix_quarter(0, 5, 10, 15);
        mix_quarter(1, 6, 11, 12);
        mix_quarter(2, 7, 8, 13);
        mix_quarter(3, 4, 9, 14);
      end
    end
    for (int i = 0; i < 16; i++) key_words[i] = mix[i] + init_w[i];
  endfunction

  // Encrypt one message word and advance position and counter
  function automatic cipher_word_t encrypt_word(word_t data, logic eom);
    cipher_word_t r;
    if (!msg_open) begin
      blk_ctr  = cfg_shadow[CFG_WORDS_12_13][31:0];
      msg_open = 1'b1;
    end
    if (word_pos == 4'd0) build_keystream();
    r.cipher = data ^ key_words[word_pos];
    r.last   = eom;
    if (eom) begin
      word_pos  = '0;
      msg_open  = 1'b0;
      msg_count = msg_count + 1;
    end else begin
      word_pos = word_pos + 4'd1;
      if (word_pos == 4'd0) blk_ctr = blk_ctr + 32'd1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < 20) begin
      $display("MISMATCH %s: got %h want %h at result %0d", what, got, want, words_seen);
    end
    err_count++;
  endtask

  // Driver: bursts of words with random gaps, fed from the pending queue
  int          burst_left = 1;
  int          gap_left   = 0;
  plain_word_t next_w;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      data_word_i      <= '0;
      end_of_message_i <= 1'b0;
    end else begin
      // predict on accept
      if (in_valid_i && !in_stall_o) begin
        expected_cipher_q.push_back(encrypt_word(data_word_i, end_of_message_i));
        words_sent++;
      end
      // load the next word or idle
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || plain_word_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          next_w            = plain_word_q.pop_front();
          in_valid_i       <= 1'b1;
          data_word_i      <= next_w.data;
          end_of_message_i <= next_w.eom;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            if ($urandom_range(0, 3) == 0) gap_left <= 0;
            else if ($urandom_range(0, 15) == 0) gap_left <= $urandom_range(20, 90);
            else gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: stall on a changing pattern, check each accepted word
  int           stall_mode = 0;
  int           mode_left  = 0;
  int           stall_tick = 0;
  cipher_word_t want_c;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cipher_q.size() == 0) begin
          report_mismatch("unexpected cipher word", cipher_word_o, '0);
        end else begin
          want_c = expected_cipher_q.pop_front();
          if (cipher_word_o !== want_c.cipher)
            report_mismatch("cipher_word", cipher_word_o, want_c.cipher);
          if (last_o !== want_c.last)
            report_mismatch("last", {31'd0, last_o}, {31'd0, want_c.last});
        end
        words_seen++;
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= (stall_tick % 7 < 3);
      endcase
    end
  end

  // Register write; call at a clock edge, leaves valid high after the handshake
  task automatic write_cfg(logic [3:0] idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < CfgCount) cfg_shadow[idx[2:0]] = value;
    cfg_writes++;
  endtask

  function automatic logic [63:0] pick_cfg_value(int idx);
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    if (idx == CFG_WORDS_12_13 && $urandom_range(0, 2) == 0)
      v[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 2);
    return v;
  endfunction

  task automatic reconfigure(bit write_all);
    for (int i = 0; i < CfgCount; i++) begin
      if (write_all || $urandom_range(0, 1) == 1) write_cfg(4'(i), pick_cfg_value(i));
    end
    if ($urandom_range(0, 2) == 0)
      write_cfg(4'($urandom_range(CfgCount, 15)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(1, 4);
      3, 4, 5: return $urandom_range(5, 20);
      6, 7:    return 16 * $urandom_range(1, 3);
      8:       return 16 * $urandom_range(1, 3) + (($urandom_range(0, 1) == 1) ? 1 : -1);
      default: return $urandom_range(21, 70);
    endcase
  endfunction

  // Queue whole messages; optionally leave one open across the next reload
  task automatic queue_messages(int target, bit leave_open);
    int queued;
    int len;
    plain_word_t w;
    queued = 0;
    while (queued < target) begin
      len = pick_length();
      for (int i = 0; i < len; i++) begin
        w.data = $urandom;
        w.eom  = (i == len - 1);
        plain_word_q.push_back(w);
      end
      queued += len;
    end
    if (leave_open) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        w.data = $urandom;
        w.eom  = 1'b0;
        plain_word_q.push_back(w);
      end
    end
  endtask

  task automatic push_word(word_t data, logic eom);
    plain_word_t w;
    w.data = data;
    w.eom  = eom;
    plain_word_q.push_back(w);
  endtask

  // Hold until every queued word is sent and every result is back;
  // poll between edges so the driver's updates of this edge have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (plain_word_q.size() != 0 || in_valid_i || expected_cipher_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: single-word messages at the data extremes
    push_word(32'h0000_0000, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // all-ones block with the counter at its top: wrap inside one message
    for (int i = 0; i < CfgCount; i++) write_cfg(4'(i), '1);
    write_cfg(4'(CfgCount), {$urandom, $urandom});
    write_cfg(4'd15, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 17; i++) begin
      case (i % 3)
        0:       push_word(32'h0000_0000, i == 16);
        1:       push_word(32'hFFFF_FFFF, i == 16);
        default: push_word($urandom, i == 16);
      endcase
    end
    push_word($urandom, 1'b1);
    wait_drained();

    // random phases with register reloads in between
    for (int phase = 0; phase < 10; phase++) begin
      reconfigure(phase == 0);
      queue_messages(140, phase % 3 == 1);
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    $display("run covered %0d words in %0d finished messages, %0d register writes",
             words_sent, msg_count, cfg_writes);
    $display("%0d cipher words compared, %0d mismatches", words_seen, err_count);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(12 * 1200000);
    $display("timeout after %0d words sent, %0d seen", words_sent, words_seen);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
